### rtl/core/rgb_3x3_convolution_defines.svh
// Assertion macros for the RGB 3x3 convolution block
`ifndef RGB_3X3_CONVOLUTION_DEFINES_SVH
`define RGB_3X3_CONVOLUTION_DEFINES_SVH
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

### rtl/core/rgbconv_pkg.sv
// Package: types, constants and helpers of the RGB 3x3 convolution block
`default_nettype none
package rgbconv_pkg;
  localparam int MaxWidth  = 1024;
  localparam int MaxHeight = 1024;
  localparam int CoeffBits = 16;
  localparam int AddrW     = $clog2(MaxWidth);
  localparam int RowW      = $clog2(MaxHeight);
  localparam int PixW      = 24;
  localparam int SumW      = 28;

  typedef enum logic [2:0] {
    REG_COEFF_TOP    = 3'd0,
    REG_COEFF_MID    = 3'd1,
    REG_COEFF_BOTTOM = 3'd2,
    REG_DIVISOR      = 3'd3,
    REG_WIDTH        = 3'd4,
    REG_HEIGHT       = 3'd5
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_READ  = 3'd1,
    ST_MAC   = 3'd2,
    ST_DIV   = 3'd3,
    ST_OUT   = 3'd4,
    ST_START = 3'd5
  } state_e;

  typedef struct packed {
    logic [AddrW-1:0] col;
    logic             emit;
    logic             row_end;
    logic             frame_end;
  } pos_t;

  function automatic logic signed [CoeffBits-1:0] coeff_at(input logic [47:0] r,
                                                           input logic [1:0] c);
    logic [15:0] raw;
    raw = r[c*16 +: 16];
    return raw[CoeffBits-1:0];
  endfunction

  function automatic logic [1:0] tap_row(input logic [3:0] t);
    if (t >= 4'd6) return 2'd2;
    if (t >= 4'd3) return 2'd1;
    return 2'd0;
  endfunction

  function automatic logic [1:0] tap_col(input logic [3:0] t);
    logic [3:0] base;
    base = {1'b0, tap_row(t), 1'b0} + {2'b0, tap_row(t)};
    return 2'(t - base);
  endfunction

  function automatic logic [7:0] clamp8(input logic signed [SumW-1:0] v);
    if (v < 0) return 8'd0;
    if (v > 255) return 8'd255;
    return v[7:0];
  endfunction
endpackage
`default_nettype wire

### rtl/core/rgbconv_line_ram.sv
// Line store: two 24-bit rows held side by side in one synchronous RAM
`default_nettype none
module rgbconv_line_ram
  import rgbconv_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               we_i,
  input  wire logic [AddrW-1:0]   addr_i,
  input  wire logic [2*PixW-1:0]  wdata_i,
  output logic      [2*PixW-1:0]  rdata_o
);
  logic [2*PixW-1:0] mem [MaxWidth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end
endmodule
`default_nettype wire

### rtl/core/rgbconv_divider.sv
// Signed restoring divider, truncating toward zero, one quotient bit a cycle
`default_nettype none
module rgbconv_divider
  import rgbconv_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  input  wire logic signed [SumW-1:0] dividend_i,
  input  wire logic signed [7:0]      divisor_i,
  output logic                        done_o,
  output logic signed [SumW-1:0]      quotient_o
);
  localparam int CntW = $clog2(SumW + 1);
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [SumW-1:0] num_q, num_d;
  logic [8:0]      rem_q, rem_d;
  logic [7:0]      den_q, den_d;
  logic            neg_q, neg_d, busy_q, busy_d;
  logic [8:0]      trial;

  always_comb begin
    cnt_d = cnt_q; num_d = num_q; rem_d = rem_q; den_d = den_q;
    neg_d = neg_q; busy_d = busy_q;
    trial = {rem_q[7:0], num_q[SumW-1]};
    if (start_i) begin
      num_d  = dividend_i[SumW-1] ? SumW'(-dividend_i) : dividend_i;
      den_d  = divisor_i[7] ? 8'(-divisor_i) : divisor_i;
      neg_d  = dividend_i[SumW-1] ^ divisor_i[7];
      rem_d  = '0;
      cnt_d  = CntW'(SumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        num_d = {num_q[SumW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        num_d = {num_q[SumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d; rem_q <= rem_d; den_q <= den_d; neg_q <= neg_d;
  end

  assign done_o     = busy_q && (cnt_q == CntW'(1));
  assign quotient_o = neg_q ? -$signed(num_d) : $signed(num_d);
endmodule
`default_nettype wire

### rtl/core/rgb_3x3_convolution.sv
// Top level: RGB 3x3 convolution over a raster pixel stream
//  channel | direction | handshake            | payload
//  pixel   | in        | in_valid / in_ready  | pixel_red/green/blue, frame_start
//  result  | out       | out_valid / out_ready| out_red/green/blue, row_end, frame_end
//  config  | in        | cfg_we               | cfg_index, cfg_data
// A border pixel is accepted with its RAM read, then stored. An interior pixel is
// accepted, stored, put through one multiply-accumulate per kernel tap and loaded
// as a result; when the divisor is neither one nor zero, each channel is divided first.
// The result register frees the input side; a waiting result holds the load.
// Reset clears position and window, loads an identity kernel, divisor 1, size 1024x1024; line RAM is not cleared.
`default_nettype none
module rgb_3x3_convolution
  import rgbconv_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  pixel_red_i,
  input  wire logic [7:0]  pixel_green_i,
  input  wire logic [7:0]  pixel_blue_i,
  input  wire logic        frame_start_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       out_red_o,
  output logic [7:0]       out_green_o,
  output logic [7:0]       out_blue_o,
  output logic             row_end_o,
  output logic             frame_end_o,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [47:0] cfg_data_i
);
`include "rgb_3x3_convolution_defines.svh"
  logic [47:0] coef_q [3];
  logic [7:0]  div_q;
  logic [10:0] width_q, height_q;
  logic [10:0] w_eff, h_eff;
  state_e      st_q, st_d;
  logic [AddrW-1:0] col_q, col_d;
  logic [RowW-1:0]  row_q, row_d;
  logic [PixW-1:0]  win_q [9];
  logic [PixW-1:0]  pix_q;
  pos_t        pos_q, pos_d;
  logic        ram_we;
  logic [AddrW-1:0] ram_addr;
  logic [2*PixW-1:0] ram_rd;
  logic [3:0]  tap_q, tap_d;
  logic [1:0]  ch_q, ch_d;
  logic signed [SumW-1:0] acc_q [3];
  logic [7:0]  res_q [3];
  logic        ov_q, ov_d, dstart, ddone, divide;
  logic signed [SumW-1:0] quot;
  logic [10:0] c_n, r_n;
  logic [3:0]  ti;
  logic        ld_out;

  assign ram_addr = (st_q == ST_IDLE) ? col_d : col_q;

  rgbconv_line_ram u_ram (
    .clk_i(clk_i), .we_i(ram_we), .addr_i(ram_addr),
    .wdata_i({ram_rd[PixW-1:0], pix_q}), .rdata_o(ram_rd)
  );
  rgbconv_divider u_div (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(dstart), .dividend_i(acc_q[ch_q]),
    .divisor_i(div_q), .done_o(ddone), .quotient_o(quot)
  );

  assign w_eff = (width_q < 11'd3) ? 11'd3 : (width_q > 11'(MaxWidth)) ?
                 11'(MaxWidth) : width_q;
  assign h_eff = (height_q < 11'd3) ? 11'd3 : (height_q > 11'(MaxHeight)) ?
                 11'(MaxHeight) : height_q;
  assign divide = (div_q != 8'd1) && (div_q != 8'd0);
  assign in_ready_o = (st_q == ST_IDLE);
  assign ti = (tap_q < 4'd9) ? tap_q : 4'd0;

  always_comb begin
    st_d = st_q; col_d = col_q; row_d = row_q; pos_d = pos_q;
    tap_d = tap_q; ch_d = ch_q; ov_d = ov_q; ram_we = 1'b0; dstart = 1'b0;
    ld_out = 1'b0;
    c_n = 11'(col_q); r_n = 11'(row_q);
    if (ov_q && out_ready_i) ov_d = 1'b0;
    unique case (st_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (frame_start_i) begin c_n = '0; r_n = '0; end
          if (c_n >= w_eff) begin c_n = '0; r_n = r_n + 11'd1; end
          if (r_n >= h_eff) r_n = '0;
          col_d = AddrW'(c_n); row_d = RowW'(r_n);
          st_d = ST_READ;
        end
      end
      ST_READ: begin
        ram_we = 1'b1;
        pos_d.col = col_q;
        pos_d.emit = (row_q >= RowW'(2)) && (col_q >= AddrW'(2));
        pos_d.row_end = (11'(col_q) == w_eff - 11'd1);
        pos_d.frame_end = pos_d.row_end && (11'(row_q) == h_eff - 11'd1);
        c_n = 11'(col_q) + 11'd1;
        if (c_n >= w_eff) begin
          c_n = '0; r_n = 11'(row_q) + 11'd1;
          if (r_n >= h_eff) r_n = '0;
        end
        col_d = AddrW'(c_n); row_d = RowW'(r_n);
        tap_d = '0; ch_d = '0;
        st_d = pos_d.emit ? ST_MAC : ST_IDLE;
      end
      ST_MAC: begin
        if (tap_q == 4'd8) begin
          if (divide) begin st_d = ST_START; ch_d = '0; end
          else st_d = ST_OUT;
        end
        tap_d = tap_q + 4'd1;
      end
      ST_START: begin
        dstart = 1'b1;
        st_d = ST_DIV;
      end
      ST_DIV: begin
        if (ddone) begin
          if (ch_q == 2'd2) st_d = ST_OUT;
          else begin ch_d = ch_q + 2'd1; st_d = ST_START; end
        end
      end
      ST_OUT: begin
        if (!ov_q) begin ld_out = 1'b1; ov_d = 1'b1; st_d = ST_IDLE; end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE; col_q <= '0; row_q <= '0; ov_q <= 1'b0;
      tap_q <= '0; ch_q <= '0;
      pos_q <= '0;
      coef_q[0] <= '0; coef_q[1] <= 48'd65536; coef_q[2] <= '0;
      div_q <= 8'd1; width_q <= 11'd1024; height_q <= 11'd1024;
      for (int i = 0; i < 9; i++) win_q[i] <= '0;
    end else begin
      st_q <= st_d; col_q <= col_d; row_q <= row_d; ov_q <= ov_d;
      tap_q <= tap_d; ch_q <= ch_d; pos_q <= pos_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_COEFF_TOP:    coef_q[0] <= cfg_data_i;
          REG_COEFF_MID:    coef_q[1] <= cfg_data_i;
          REG_COEFF_BOTTOM: coef_q[2] <= cfg_data_i;
          REG_DIVISOR:      div_q <= cfg_data_i[7:0];
          REG_WIDTH:        width_q <= cfg_data_i[10:0];
          REG_HEIGHT:       height_q <= cfg_data_i[10:0];
          default: ;
        endcase
      end
      if (st_q == ST_READ) begin
        for (int r = 0; r < 3; r++) begin
          win_q[r*3]   <= win_q[r*3+1];
          win_q[r*3+1] <= win_q[r*3+2];
        end
        win_q[2] <= ram_rd[2*PixW-1:PixW];
        win_q[5] <= ram_rd[PixW-1:0];
        win_q[8] <= pix_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == ST_IDLE && in_valid_i) pix_q <= {pixel_blue_i, pixel_green_i, pixel_red_i};
    if (st_q == ST_READ) for (int k = 0; k < 3; k++) acc_q[k] <= '0;
    if (st_q == ST_MAC) begin
      for (int k = 0; k < 3; k++) begin
        acc_q[k] <= acc_q[k] + SumW'($signed({1'b0, win_q[ti][k*8 +: 8]}) *
                    coeff_at(coef_q[tap_row(ti)], tap_col(ti)));
      end
    end
    if (st_q == ST_DIV && ddone) acc_q[ch_q] <= quot;
    if (ld_out) begin
      for (int k = 0; k < 3; k++) res_q[k] <= clamp8(acc_q[k]);
      row_end_o <= pos_q.row_end;
      frame_end_o <= pos_q.frame_end;
    end
  end

  assign out_valid_o = ov_q;
  assign out_red_o   = res_q[0];
  assign out_green_o = res_q[1];
  assign out_blue_o  = res_q[2];

  `ASSERT_IMPL(a_ready_idle, in_ready_o, st_q == ST_IDLE)
  `ASSERT_NEXT(a_border_no_mac, st_q == ST_READ && !pos_d.emit, st_q == ST_IDLE)
  `ASSERT_NEXT(a_out_hold, ov_q && !out_ready_i, ov_q)
  `ASSERT_IMPL(a_frame_row, ov_q && frame_end_o, row_end_o)
  `ASSERT_IMPL(a_div_only, st_q == ST_DIV, divide)
endmodule
`default_nettype wire

### tb/testbench.sv
// Testbench for the RGB 3x3 convolution block: directed and random frames
`timescale 1ns / 100ps
`default_nettype none
module testbench;
  import rgbconv_pkg::*;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       row_end;
    logic       frame_end;
  } filtered_pixel_t;

  localparam int IdleLimit = 2000;
  localparam int SettleCycles = 100;
  localparam int RandomPixels = 600;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  pixel_red = '0;
  logic [7:0]  pixel_green = '0;
  logic [7:0]  pixel_blue = '0;
  logic        frame_start = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;
  logic        row_end;
  logic        frame_end;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [47:0] cfg_data = '0;

  rgb_3x3_convolution uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .pixel_red_i   (pixel_red),
    .pixel_green_i (pixel_green),
    .pixel_blue_i  (pixel_blue),
    .frame_start_i (frame_start),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .out_red_o     (out_red),
    .out_green_o   (out_green),
    .out_blue_o    (out_blue),
    .row_end_o     (row_end),
    .frame_end_o   (frame_end),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  always #5 clk_i = ~clk_i;

  // shadow registers and state of the filter
  logic [47:0] kernel_top = 48'd0;
  logic [47:0] kernel_mid = 48'h0000_0001_0000;
  logic [47:0] kernel_bottom = 48'd0;
  logic [7:0]  divisor = 8'd1;
  logic [10:0] width_reg = 11'd1024;
  logic [10:0] height_reg = 11'd1024;
  logic [23:0] prev_line [MaxWidth];
  logic [23:0] older_line [MaxWidth];
  logic [23:0] window [9];
  int          col_pos = 0;
  int          row_pos = 0;

  filtered_pixel_t pending_pixels[$];
  int errors = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  bit gaps_on = 1'b1;
  int hold_token = 0;
  int hold_len = 0;

  function automatic int kernel_coeff(input logic [47:0] row, input int c);
    logic signed [15:0] v;
    v = row[c*16 +: 16];
    return int'(v);
  endfunction

  function automatic logic [7:0] filter_channel(input int shift, input int d);
    logic [47:0] rows [3];
    int sum;
    rows[0] = kernel_top;
    rows[1] = kernel_mid;
    rows[2] = kernel_bottom;
    sum = 0;
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        sum += int'(window[r*3+c][shift +: 8]) * kernel_coeff(rows[r], c);
    if (d != 1) sum = sum / d;
    if (sum < 0) sum = 0;
    if (sum > 255) sum = 255;
    return 8'(sum);
  endfunction

  function automatic int clip_size(input logic [10:0] v, input int maxv);
    if (v < 3) return 3;
    if (v > maxv) return maxv;
    return int'(v);
  endfunction

  function automatic void predict_pixel(input logic [7:0] r, input logic [7:0] g,
                                        input logic [7:0] b, input logic fs);
    int w, h, col, row, d;
    logic [23:0] above, above2;
    filtered_pixel_t res;
    w = clip_size(width_reg, MaxWidth);
    h = clip_size(height_reg, MaxHeight);
    if (fs) begin
      col_pos = 0;
      row_pos = 0;
    end
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= h) row_pos = 0;
    col = col_pos;
    row = row_pos;
    above = prev_line[col];
    above2 = older_line[col];
    for (int i = 0; i < 3; i++) begin
      window[i*3] = window[i*3+1];
      window[i*3+1] = window[i*3+2];
    end
    window[2] = above2;
    window[5] = above;
    window[8] = {b, g, r};
    older_line[col] = above;
    prev_line[col] = {b, g, r};
    if (row >= 2 && col >= 2) begin
      d = int'($signed(divisor));
      if (d == 0) d = 1;
      res.red = filter_channel(0, d);
      res.green = filter_channel(8, d);
      res.blue = filter_channel(16, d);
      res.row_end = (col == w - 1);
      res.frame_end = (col == w - 1) && (row == h - 1);
      pending_pixels.push_back(res);
    end
    col++;
    if (col >= w) begin
      col = 0;
      row++;
      if (row >= h) row = 0;
    end
    col_pos = col;
    row_pos = row;
  endfunction

  function automatic logic [47:0] kernel_row(input int left, input int centre, input int right);
    return {16'(right), 16'(centre), 16'(left)};
  endfunction

  // result side: stall pattern and long hold
  int hold_seen = 0;
  int hold_left = 0;
  int mode_left = 0;
  int ready_mode = 0;
  logic [7:0] ready_pattern = 8'hff;
  int pattern_phase = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else if (hold_seen != hold_token) begin
      hold_seen <= hold_token;
      hold_left <= hold_len;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        ready_mode <= $urandom_range(0, 2);
        mode_left <= $urandom_range(50, 300);
        ready_pattern <= 8'($urandom) | 8'h01;
      end else begin
        mode_left <= mode_left - 1;
      end
      pattern_phase <= (pattern_phase + 1) % 8;
      case (ready_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        default: out_ready <= ready_pattern[pattern_phase];
      endcase
    end
  end

  always @(posedge clk_i) begin
    filtered_pixel_t exp_px;
    if (rst_ni && out_valid && out_ready) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected result r=%h g=%h b=%h", $time, out_red, out_green,
                 out_blue);
        errors++;
      end else begin
        exp_px = pending_pixels.pop_front();
        if (out_red !== exp_px.red) begin
          $display("%0t: red expected %h actual %h", $time, exp_px.red, out_red);
          errors++;
        end
        if (out_green !== exp_px.green) begin
          $display("%0t: green expected %h actual %h", $time, exp_px.green, out_green);
          errors++;
        end
        if (out_blue !== exp_px.blue) begin
          $display("%0t: blue expected %h actual %h", $time, exp_px.blue, out_blue);
          errors++;
        end
        if (row_end !== exp_px.row_end) begin
          $display("%0t: row_end expected %b actual %b", $time, exp_px.row_end, row_end);
          errors++;
        end
        if (frame_end !== exp_px.frame_end) begin
          $display("%0t: frame_end expected %b actual %b", $time, exp_px.frame_end,
                   frame_end);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                            input logic fs);
    int gap;
    if (gaps_on && burst_left == 0) begin
      gap = $urandom_range(1, 8);
      burst_left = $urandom_range(1, 24);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    if (burst_left > 0) burst_left--;
    in_valid <= 1'b1;
    pixel_red <= r;
    pixel_green <= g;
    pixel_blue <= b;
    frame_start <= fs;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    predict_pixel(r, g, b, fs);
  endtask

  task automatic send_random_pixels(input int count, input bit first_starts);
    for (int i = 0; i < count; i++)
      send_pixel(8'($urandom), 8'($urandom), 8'($urandom), first_starts && i == 0);
  endtask

  task automatic await_results();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
  endtask

  // drain and let any border pixel still in flight finish
  task automatic settle();
    await_results();
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [47:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_COEFF_TOP:    kernel_top = value;
      REG_COEFF_MID:    kernel_mid = value;
      REG_COEFF_BOTTOM: kernel_bottom = value;
      REG_DIVISOR:      divisor = value[7:0];
      REG_WIDTH:        width_reg = value[10:0];
      REG_HEIGHT:       height_reg = value[10:0];
      default: ;
    endcase
  endtask

  task automatic set_size(input int w, input int h);
    write_reg(REG_WIDTH, 48'(w));
    write_reg(REG_HEIGHT, 48'(h));
  endtask

  task automatic test_directed();
    logic [7:0] levels [9];
    levels = '{8'h00, 8'hff, 8'h80, 8'h7f, 8'h01, 8'hfe, 8'h55, 8'haa, 8'hff};
    // undersized width and height act as three
    set_size(0, 2);
    for (int i = 0; i < 9; i++)
      send_pixel(levels[i], ~levels[i], levels[8-i], i == 0);
    settle();
    write_reg(REG_COEFF_TOP, kernel_row(32767, -32768, 1));
    write_reg(REG_COEFF_MID, kernel_row(-1, 32767, -32768));
    write_reg(REG_COEFF_BOTTOM, kernel_row(2, -2, 32767));
    write_reg(REG_DIVISOR, 48'h00);
    for (int i = 0; i < 9; i++)
      send_pixel(levels[8-i], levels[i], 8'hff, i == 0);
    settle();
    write_reg(REG_DIVISOR, 48'h80);
    for (int i = 0; i < 9; i++)
      send_pixel(8'hff, levels[i], 8'h00, i == 0);
    settle();
  endtask

  task automatic test_resize_mid_frame();
    write_reg(REG_COEFF_TOP, kernel_row(1, 2, 1));
    write_reg(REG_COEFF_MID, kernel_row(2, 4, 2));
    write_reg(REG_COEFF_BOTTOM, kernel_row(1, 2, 1));
    write_reg(REG_DIVISOR, 48'd16);
    set_size(8, 6);
    send_random_pixels(21, 1'b1);
    settle();
    // column now past the new width: wraps onto the next row
    set_size(4, 5);
    send_random_pixels(30, 1'b0);
    settle();
    // restart part-way through an image
    send_random_pixels(7, 1'b1);
    send_random_pixels(20, 1'b1);
    settle();
  endtask

  task automatic test_oversize();
    write_reg(REG_DIVISOR, 48'h7f);
    write_reg(REG_COEFF_MID, kernel_row(100, 127, 100));
    set_size(2047, 3);
    send_random_pixels(MaxWidth + 6, 1'b1);
    settle();
    // clamped width has already moved on to the second row
    write_reg(REG_WIDTH, 48'd8);
    send_random_pixels(10, 1'b0);
    settle();
    write_reg(REG_DIVISOR, 48'h01);
    write_reg(REG_COEFF_MID, kernel_row(0, 1, 0));
    set_size(3, 2047);
    send_random_pixels(36, 1'b1);
    settle();
  endtask

  task automatic test_backpressure();
    set_size(6, 5);
    write_reg(REG_DIVISOR, 48'h00);
    hold_len = 400;
    hold_token++;
    gaps_on = 1'b0;
    send_random_pixels(30, 1'b1);
    await_results();
    gaps_on = 1'b1;
    send_random_pixels(15, 1'b0);
    settle();
  endtask

  task automatic test_random_frames();
    int sent, w, h, sel;
    int k [9];
    sent = 0;
    while (sent < RandomPixels) begin
      sel = $urandom_range(0, 9);
      for (int i = 0; i < 9; i++)
        k[i] = (sel < 7) ? $urandom_range(0, 8) - 4 : int'($signed(16'($urandom)));
      write_reg(REG_COEFF_TOP, kernel_row(k[0], k[1], k[2]));
      write_reg(REG_COEFF_MID, kernel_row(k[3], k[4], k[5]));
      write_reg(REG_COEFF_BOTTOM, kernel_row(k[6], k[7], k[8]));
      case ($urandom_range(0, 5))
        0: write_reg(REG_DIVISOR, 48'h00);
        1: write_reg(REG_DIVISOR, 48'h01);
        2: write_reg(REG_DIVISOR, 48'h80);
        3: write_reg(REG_DIVISOR, 48'h7f);
        default: write_reg(REG_DIVISOR, 48'($urandom_range(0, 255)));
      endcase
      w = ($urandom_range(0, 7) == 0) ? $urandom_range(3, 40) : $urandom_range(3, 12);
      h = $urandom_range(3, 6);
      set_size(w, h);
      gaps_on = ($urandom_range(0, 3) != 0);
      for (int f = $urandom_range(1, 3); f > 0; f--) begin
        for (int i = 0; i < w * h; i++) begin
          // an odd stray start marker breaks the frame
          send_pixel(8'($urandom), 8'($urandom), 8'($urandom),
                     i == 0 || $urandom_range(0, 199) == 0);
          sent++;
        end
      end
      settle();
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_resize_mid_frame();
    test_backpressure();
    test_oversize();
    test_random_frames();
    settle();
    if (errors == 0 && pending_pixels.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
`default_nettype wire
